@@ design/rpa_pkg.sv @@
`timescale 1ns / 1ps
package rpa_pkg;
	localparam int PAGE_W  = 20;
	localparam int ZPAGE_W = 11;
	localparam int STAT_W  = 3;
	localparam int OUT_REF_W = 8;
	localparam int TOTAL_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_INCR  = 2'd1;
	localparam logic [1:0] OP_DECR  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOMEM    = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_NOTUSED  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [1:0] CFG_Z0_BASE  = 2'd0;
	localparam logic [1:0] CFG_Z0_PAGES = 2'd1;
	localparam logic [1:0] CFG_Z1_BASE  = 2'd2;
	localparam logic [1:0] CFG_Z1_PAGES = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [PAGE_W-1:0]    result_page;
		logic [OUT_REF_W-1:0] ref_count;
		logic                 page_freed;
		logic [TOTAL_W-1:0]   free_total;
	} res_t;
endpackage

@@ design/rpa_req_if.sv @@
`timescale 1ns / 1ps
interface rpa_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [rpa_pkg::PAGE_W-1:0] page;
	modport source (output valid, opcode, page, input ready);
	modport sink (input valid, opcode, page, output ready);
endinterface

@@ design/rpa_res_if.sv @@
`timescale 1ns / 1ps
interface rpa_res_if;
	logic                              valid;
	logic                              ready;
	logic [rpa_pkg::STAT_W-1:0]        status;
	logic [rpa_pkg::PAGE_W-1:0]        result_page;
	logic [rpa_pkg::OUT_REF_W-1:0]     ref_count;
	logic                              page_freed;
	logic [rpa_pkg::TOTAL_W-1:0]       free_total;
	modport source (output valid, status, result_page, ref_count, page_freed, free_total,
		input ready);
	modport sink (input valid, status, result_page, ref_count, page_freed, free_total,
		output ready);
endinterface

@@ design/rpa_front.sv @@
`timescale 1ns / 1ps
// accepts request beats, locates the owning zone and queues classified items
module rpa_front #(
	parameter int ZONES = 2,
	parameter int PAGES_PER_ZONE = 1024,
	parameter int OFF_W = 10,
	parameter int ZI_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        flush,
	rpa_req_if.sink                     req,
	input  logic [rpa_pkg::PAGE_W-1:0]  zbase [2],
	input  logic [rpa_pkg::ZPAGE_W-1:0] zpages [2],
	output logic                        q_valid,
	input  logic                        q_pop,
	output logic [1:0]                  q_op,
	output logic [rpa_pkg::PAGE_W-1:0]  q_page,
	output logic                        q_hit,
	output logic [ZI_W-1:0]             q_zone,
	output logic [OFF_W-1:0]            q_off
);
	localparam int ENT_W = 2 + rpa_pkg::PAGE_W + 1 + ZI_W + OFF_W;

	logic [ENT_W-1:0] fifo_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             hit;
	logic [ZI_W-1:0]  zone;
	logic [OFF_W-1:0] off;
	logic             push;

	// zone lookup, zone zero wins on overlap
	always_comb begin
		logic [rpa_pkg::PAGE_W:0] diff;
		logic [rpa_pkg::ZPAGE_W:0] n;
		hit = 1'b0;
		zone = '0;
		off = '0;
		for (int z = 1; z >= 0; z--) begin
			n = (int'(zpages[z]) > PAGES_PER_ZONE) ?
				(rpa_pkg::ZPAGE_W+1)'(PAGES_PER_ZONE) : {1'b0, zpages[z]};
			diff = {1'b0, req.page} - {1'b0, zbase[z]};
			if (z < ZONES && n != '0 && !diff[rpa_pkg::PAGE_W] &&
			    diff < (rpa_pkg::PAGE_W+1)'(n)) begin
				hit = 1'b1;
				zone = ZI_W'(z);
				off = diff[OFF_W-1:0];
			end
		end
	end

	assign req.ready = (cnt_q != 2'd2) && !flush;
	assign push = req.valid && req.ready;

	// two-entry queue
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= {req.opcode, req.page, hit, zone, off};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else if (flush) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid = cnt_q != '0;
	assign {q_op, q_page, q_hit, q_zone, q_off} = fifo_q[rp_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !req.ready) else $error("ready while queue full");
`endif
endmodule

@@ design/rpa_back.sv @@
`timescale 1ns / 1ps
// executes queued items against the count and link memories
module rpa_back #(
	parameter int ZONES = 2,
	parameter int PAGES_PER_ZONE = 1024,
	parameter int REF_BITS = 8,
	parameter int OFF_W = 10,
	parameter int ZI_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        reinit,
	output logic                        busy,
	input  logic [rpa_pkg::PAGE_W-1:0]  zbase [2],
	input  logic [rpa_pkg::ZPAGE_W-1:0] zpages [2],
	input  logic                        q_valid,
	output logic                        q_pop,
	input  logic [1:0]                  q_op,
	input  logic [rpa_pkg::PAGE_W-1:0]  q_page,
	input  logic                        q_hit,
	input  logic [ZI_W-1:0]             q_zone,
	input  logic [OFF_W-1:0]            q_off,
	rpa_res_if.source                   res
);
	localparam int DEPTH = 2 << OFF_W;
	localparam int AW = OFF_W + 1;
	localparam int HW = OFF_W + 1;
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_CLR  = 2'd2;

	logic [REF_BITS-1:0] refm [DEPTH];
	// links hold a stack head, including the empty marker
	logic [HW-1:0]       linkm [DEPTH];

	logic [1:0]          st_q;
	logic [AW-1:0]       clr_q;
	logic [HW-1:0]       head_q [2];
	logic [HW-1:0]       untouched_q [2];
	logic [HW-1:0]       nfree_q [2];
	logic [1:0]          op_q;
	logic [rpa_pkg::PAGE_W-1:0] page_q;
	logic                hit_q;
	logic                zone_q;
	logic [OFF_W-1:0]    off_q;
	logic                from_stack_q;
	logic [REF_BITS-1:0] ref_rd_q;
	logic [HW-1:0]       link_rd_q;
	logic                out_v_q;
	rpa_pkg::res_t       out_q;

	// allocate decision made at issue
	logic                a_ok, a_stack, a_zone;
	logic [OFF_W-1:0]    a_off;
	logic [AW-1:0]       rd_addr;
	logic [HW-1:0]       eff [2];

	always_comb begin
		for (int z = 0; z < 2; z++) begin
			eff[z] = (z >= ZONES) ? '0 :
				(int'(zpages[z]) > PAGES_PER_ZONE) ? HW'(PAGES_PER_ZONE) :
				HW'(zpages[z]);
		end
		a_ok = 1'b0;
		a_stack = 1'b0;
		a_zone = 1'b0;
		a_off = '0;
		for (int z = 1; z >= 0; z--) begin
			if (nfree_q[z] != '0 && (head_q[z] < HW'(PAGES_PER_ZONE) ||
			    untouched_q[z] != '0)) begin
				a_ok = 1'b1;
				a_zone = z[0];
				a_stack = head_q[z] < HW'(PAGES_PER_ZONE);
				a_off = a_stack ? head_q[z][OFF_W-1:0] :
					OFF_W'(untouched_q[z] - HW'(1));
			end
		end
		if (q_op == rpa_pkg::OP_ALLOC) rd_addr = {a_zone, a_off};
		else rd_addr = {q_zone, q_off};
	end

	assign busy = st_q != S_IDLE || q_valid || out_v_q;
	assign q_pop = (st_q == S_IDLE) && q_valid && (!out_v_q || res.ready) && !reinit;

	// memory read on issue, write on execute or clearing sweep
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ref_rd_q <= refm[rd_addr];
			link_rd_q <= linkm[rd_addr];
		end
		if (st_q == S_CLR) refm[clr_q] <= '0;
		else if (st_q == S_EXEC) begin
			if (op_q == rpa_pkg::OP_ALLOC) begin
				if (hit_q) refm[{zone_q, off_q}] <= REF_BITS'(1);
			end else if (hit_q && ref_rd_q != '0) begin
				if (op_q == rpa_pkg::OP_INCR && ref_rd_q != REF_MAX)
					refm[{zone_q, off_q}] <= ref_rd_q + REF_BITS'(1);
				else if (op_q == rpa_pkg::OP_DECR) begin
					refm[{zone_q, off_q}] <= ref_rd_q - REF_BITS'(1);
					if (ref_rd_q == REF_BITS'(1))
						linkm[{zone_q, off_q}] <= head_q[zone_q];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			page_q <= q_page;
			hit_q <= (q_op == rpa_pkg::OP_ALLOC) ? a_ok : q_hit;
			zone_q <= (q_op == rpa_pkg::OP_ALLOC) ? a_zone : q_zone[0];
			off_q <= (q_op == rpa_pkg::OP_ALLOC) ? a_off : q_off;
			from_stack_q <= a_stack;
		end
	end

	// sequencer, zone state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			for (int z = 0; z < 2; z++) begin
				head_q[z] <= HW'(PAGES_PER_ZONE);
				untouched_q[z] <= '0;
				nfree_q[z] <= '0;
			end
		end else if (reinit) begin
			st_q <= S_CLR;
			clr_q <= '0;
			for (int z = 0; z < 2; z++) begin
				head_q[z] <= HW'(PAGES_PER_ZONE);
				untouched_q[z] <= eff[z];
				nfree_q[z] <= eff[z];
			end
		end else begin
			if (out_v_q && res.ready) out_v_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) st_q <= S_EXEC;
				end
				S_EXEC: begin
					logic [HW-1:0] nf [2];
					nf = nfree_q;
					st_q <= S_IDLE;
					out_v_q <= 1'b1;
					out_q.page_freed <= 1'b0;
					out_q.result_page <= page_q;
					out_q.ref_count <= '0;
					out_q.status <= rpa_pkg::ST_OK;
					if (op_q == rpa_pkg::OP_ALLOC) begin
						if (!hit_q) begin
							out_q.status <= rpa_pkg::ST_NOMEM;
							out_q.result_page <= '0;
						end else begin
							if (from_stack_q) head_q[zone_q] <= link_rd_q;
							else untouched_q[zone_q] <= untouched_q[zone_q] - HW'(1);
							nf[zone_q] = nf[zone_q] - HW'(1);
							out_q.result_page <= zbase[zone_q] + rpa_pkg::PAGE_W'(off_q);
							out_q.ref_count <= 8'd1;
						end
					end else if (!hit_q) out_q.status <= rpa_pkg::ST_INVALID;
					else if (op_q == rpa_pkg::OP_READ)
						out_q.ref_count <= 8'(ref_rd_q);
					else if (ref_rd_q == '0) out_q.status <= rpa_pkg::ST_NOTUSED;
					else if (op_q == rpa_pkg::OP_INCR) begin
						if (ref_rd_q == REF_MAX) begin
							out_q.status <= rpa_pkg::ST_OVERFLOW;
							out_q.ref_count <= 8'(ref_rd_q);
						end else out_q.ref_count <= 8'(ref_rd_q + REF_BITS'(1));
					end else begin
						out_q.ref_count <= 8'(ref_rd_q - REF_BITS'(1));
						if (ref_rd_q == REF_BITS'(1)) begin
							head_q[zone_q] <= HW'(off_q);
							nf[zone_q] = nf[zone_q] + HW'(1);
							out_q.page_freed <= 1'b1;
						end
					end
					nfree_q <= nf;
					out_q.free_total <= rpa_pkg::TOTAL_W'(nf[0]) + rpa_pkg::TOTAL_W'(nf[1]);
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.status = out_q.status;
	assign res.result_page = out_q.result_page;
	assign res.ref_count = out_q.ref_count;
	assign res.page_freed = out_q.page_freed;
	assign res.free_total = out_q.free_total;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == S_IDLE) else $error("issue outside idle");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_EXEC && !reinit |=> out_v_q) else $error("execute gave no result");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLR |-> !q_pop) else $error("issue during clearing sweep");
`endif
endmodule

@@ design/refcounted_page_allocator.sv @@
`timescale 1ns / 1ps
// Reference-counted page allocator over two zones.
// Request channel req carries opcode and page; result channel res carries
// status, result_page, ref_count, page_freed and free_total, one per request.
// Zone registers are written through cfg_we / cfg_idx / cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// Any zone write empties both free stacks and starts a count clearing sweep.
// A front stage locates the page's zone and fills a two-entry queue; the
// back stage reads the count and link memories when it issues a request
// and writes them back in the next cycle, in which it also loads the result
// into the output register. It issues a new request only after the last
// has executed and while the output register is free or being taken.
// After reset, and after every zone write, a sweep over every count memory
// entry (2048 entries with the default page count) clears the count
// memory; requests queue but do not issue meanwhile.
// When the receiver stalls, the result is held and the queue fills, after
// which req.ready drops.
module refcounted_page_allocator #(
	parameter int ZONES = 2,
	parameter int PAGES_PER_ZONE = 1024,
	parameter int REF_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rpa_req_if.sink                         req,
	rpa_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int OFF_W = $clog2(PAGES_PER_ZONE);
	localparam int ZI_W = 1;

	logic [rpa_pkg::PAGE_W-1:0]  zbase_q [2];
	logic [rpa_pkg::ZPAGE_W-1:0] zpages_q [2];
	logic                        reinit_q;
	logic                        q_valid, q_pop, q_hit, busy;
	logic [1:0]                  q_op;
	logic [rpa_pkg::PAGE_W-1:0]  q_page;
	logic [ZI_W-1:0]             q_zone;
	logic [OFF_W-1:0]            q_off;

	// zone registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zbase_q[0] <= '0; zbase_q[1] <= '0;
			zpages_q[0] <= '0; zpages_q[1] <= '0;
			reinit_q <= 1'b0;
		end else begin
			reinit_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_idx)
					rpa_pkg::CFG_Z0_BASE:  zbase_q[0] <= cfg_data;
					rpa_pkg::CFG_Z0_PAGES: zpages_q[0] <= cfg_data[rpa_pkg::ZPAGE_W-1:0];
					rpa_pkg::CFG_Z1_BASE:  zbase_q[1] <= cfg_data;
					default:               zpages_q[1] <= cfg_data[rpa_pkg::ZPAGE_W-1:0];
				endcase
			end
		end
	end

	rpa_front #(.ZONES(ZONES), .PAGES_PER_ZONE(PAGES_PER_ZONE), .OFF_W(OFF_W), .ZI_W(ZI_W))
	u_front (
		.clk, .arst_n, .flush(reinit_q), .req, .zbase(zbase_q), .zpages(zpages_q),
		.q_valid, .q_pop, .q_op, .q_page, .q_hit, .q_zone, .q_off
	);

	rpa_back #(.ZONES(ZONES), .PAGES_PER_ZONE(PAGES_PER_ZONE), .REF_BITS(REF_BITS),
		.OFF_W(OFF_W), .ZI_W(ZI_W))
	u_back (
		.clk, .arst_n, .reinit(reinit_q), .busy, .zbase(zbase_q), .zpages(zpages_q),
		.q_valid, .q_pop, .q_op, .q_page, .q_hit, .q_zone, .q_off, .res
	);

`ifndef SYNTHESIS
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		reinit_q |-> !q_pop) else $error("issue during zone reconfiguration");
	a_busy_res: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> busy) else $error("result while not busy");
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.page_freed |-> res.status == rpa_pkg::ST_OK)
		else $error("freed flag with error status");
`endif
endmodule

@@ bench/refcounted_page_allocator_test.sv @@
`timescale 1ns / 1ps
module refcounted_page_allocator_test;
	localparam int PPZ = 1024;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rpa_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	rpa_req_if req ();
	rpa_res_if res ();

	refcounted_page_allocator DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow allocator state
	logic [19:0] zbase [2];
	logic [10:0] zpages [2];
	logic [7:0]  counts [2*PPZ];
	logic [10:0] links [2*PPZ];
	logic [10:0] stack_top [2];
	logic [10:0] fresh_left [2];
	logic [10:0] zfree [2];

	rpa_pkg::res_t expected_q [$];
	int errors = 0;
	int sender_idle = 0;
	int recv_stall = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int quiet = 0;

	function automatic int zone_size(int z);
		return (int'(zpages[z]) > PPZ) ? PPZ : int'(zpages[z]);
	endfunction

	function automatic void clear_zones();
		for (int i = 0; i < 2*PPZ; i++) counts[i] = '0;
		for (int z = 0; z < 2; z++) begin
			stack_top[z] = 11'(PPZ);
			fresh_left[z] = 11'(zone_size(z));
			zfree[z] = 11'(zone_size(z));
		end
	endfunction

	function automatic void shadow_write(logic [1:0] idx, logic [19:0] data);
		if (idx == rpa_pkg::CFG_Z0_BASE) zbase[0] = data;
		else if (idx == rpa_pkg::CFG_Z0_PAGES) zpages[0] = data[10:0];
		else if (idx == rpa_pkg::CFG_Z1_BASE) zbase[1] = data;
		else zpages[1] = data[10:0];
		clear_zones();
	endfunction

	// next result of the allocator, updating the shadow state
	function automatic rpa_pkg::res_t allocator_step(logic [1:0] op, logic [19:0] page);
		rpa_pkg::res_t r;
		int z;
		int hit;
		int off;
		int idx;
		logic [19:0] diff;
		r = '0;
		r.result_page = page;
		hit = -1;
		off = 0;
		if (op == rpa_pkg::OP_ALLOC) begin
			r.result_page = '0;
			r.status = rpa_pkg::ST_NOMEM;
			for (z = 0; z < 2 && hit < 0; z++) begin
				if (zfree[z] == 0) continue;
				if (int'(stack_top[z]) < PPZ) begin
					off = int'(stack_top[z]);
					stack_top[z] = links[z*PPZ + off];
				end else if (fresh_left[z] != 0) begin
					fresh_left[z]--;
					off = int'(fresh_left[z]);
				end else continue;
				hit = z;
				zfree[z]--;
				counts[z*PPZ + off] = 8'd1;
				r.result_page = zbase[z] + off[19:0];
				r.ref_count = 8'd1;
				r.status = rpa_pkg::ST_OK;
			end
		end else begin
			for (z = 0; z < 2 && hit < 0; z++) begin
				diff = page - zbase[z];
				if (zone_size(z) != 0 && page >= zbase[z] && int'(diff) < zone_size(z)) begin
					hit = z;
					off = int'(diff);
				end
			end
			if (hit < 0) r.status = rpa_pkg::ST_INVALID;
			else begin
				idx = hit*PPZ + off;
				if (op == rpa_pkg::OP_READ) r.ref_count = counts[idx];
				else if (counts[idx] == 0) r.status = rpa_pkg::ST_NOTUSED;
				else if (op == rpa_pkg::OP_INCR) begin
					if (counts[idx] == 8'hFF) begin
						r.status = rpa_pkg::ST_OVERFLOW;
						r.ref_count = counts[idx];
					end else begin
						counts[idx]++;
						r.ref_count = counts[idx];
					end
				end else begin
					counts[idx]--;
					r.ref_count = counts[idx];
					if (counts[idx] == 0) begin
						links[idx] = stack_top[hit];
						stack_top[hit] = 11'(off);
						zfree[hit]++;
						r.page_freed = 1'b1;
					end
				end
			end
		end
		r.free_total = 12'(zfree[0]) + 12'(zfree[1]);
		return r;
	endfunction

	// offer one request beat, expectation given or from the shadow
	task automatic send(logic [1:0] op, logic [19:0] page, bit typed, rpa_pkg::res_t given);
		rpa_pkg::res_t p;
		p = allocator_step(op, page);
		expected_q.push_back(typed ? given : p);
		if ($urandom_range(99) < sender_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.page <= page;
		do @(posedge clk); while (!req.ready);
	endtask

	// zone registers change only with nothing outstanding
	task automatic write_reg(logic [1:0] idx, logic [19:0] data);
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_write(idx, data);
	endtask

	task automatic set_zones(logic [19:0] b0, logic [19:0] n0, logic [19:0] b1, logic [19:0] n1);
		write_reg(rpa_pkg::CFG_Z0_BASE, b0);
		write_reg(rpa_pkg::CFG_Z0_PAGES, n0);
		write_reg(rpa_pkg::CFG_Z1_BASE, b1);
		write_reg(rpa_pkg::CFG_Z1_PAGES, n1);
	endtask

	// pages mostly near the top of a zone, where allocations land
	function automatic logic [19:0] pick_page();
		int z;
		int n;
		int span;
		z = $urandom_range(1);
		n = zone_size(z);
		if ($urandom_range(99) < 10 || n == 0) return 20'($urandom);
		span = (n < 12) ? n : 12;
		return zbase[z] + 20'(n - 1 - int'($urandom_range(span - 1)));
	endfunction

	task automatic random_items(int n, bit incr_heavy);
		int w;
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(99);
			if (incr_heavy)
				op = (w < 5) ? rpa_pkg::OP_ALLOC : (w < 85) ? rpa_pkg::OP_INCR :
					(w < 90) ? rpa_pkg::OP_DECR : rpa_pkg::OP_READ;
			else
				op = (w < 30) ? rpa_pkg::OP_ALLOC : (w < 50) ? rpa_pkg::OP_INCR :
					(w < 85) ? rpa_pkg::OP_DECR : rpa_pkg::OP_READ;
			send(op, pick_page(), 1'b0, '0);
		end
	endtask

	// result side: check beats, random stall, long hold-off, watchdog
	always @(posedge clk) begin
		rpa_pkg::res_t got;
		rpa_pkg::res_t want;
		if (res.valid && res.ready) begin
			got = '{res.status, res.result_page, res.ref_count, res.page_freed, res.free_total};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $realtime, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected st=%0d pg=%h ref=%0d freed=%0d total=%0d",
						$realtime, want.status, want.result_page, want.ref_count,
						want.page_freed, want.free_total);
					$display("%0t:   actual st=%0d pg=%h ref=%0d freed=%0d total=%0d",
						$realtime, got.status, got.result_page, got.ref_count,
						got.page_freed, got.free_total);
					errors++;
				end
			end
		end
		if ((res.valid && res.ready) || (req.valid && req.ready)) quiet = 0;
		else quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("refcounted_page_allocator: mismatch");
			$finish;
		end
		// long enough to outlast the clearing sweep and then fill the queue
		if (hold_req && hold_cnt == 0) begin
			hold_req = 0;
			hold_cnt = 3000;
		end
		if (hold_cnt > 0) hold_cnt--;
		res.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall);
	end

	typedef struct {
		bit            is_cfg;
		logic [1:0]    op;
		logic [19:0]   page;
		bit            typed;
		rpa_pkg::res_t want;
	} step_t;

	step_t plan [$];

	function automatic void add(bit c, logic [1:0] op, logic [19:0] page, bit t,
		rpa_pkg::res_t w);
		step_t s;
		s.is_cfg = c;
		s.op = op;
		s.page = page;
		s.typed = t;
		s.want = w;
		plan.push_back(s);
	endfunction

	initial begin
		req.valid = 1'b0;
		req.opcode = rpa_pkg::OP_ALLOC;
		req.page = '0;
		res.ready = 1'b0;
		zbase[0] = '0; zbase[1] = '0; zpages[0] = '0; zpages[1] = '0;
		for (int i = 0; i < 2*PPZ; i++) links[i] = '0;
		clear_zones();

		// no zones after reset: everything fails
		add(0, rpa_pkg::OP_ALLOC, 20'h12345, 1,
			'{rpa_pkg::ST_NOMEM, 20'h0, 8'd0, 1'b0, 12'd0});
		add(0, rpa_pkg::OP_INCR, 20'h0, 1,
			'{rpa_pkg::ST_INVALID, 20'h0, 8'd0, 1'b0, 12'd0});
		add(0, rpa_pkg::OP_DECR, 20'hFFFFF, 1,
			'{rpa_pkg::ST_INVALID, 20'hFFFFF, 8'd0, 1'b0, 12'd0});
		add(0, rpa_pkg::OP_READ, 20'h5, 1,
			'{rpa_pkg::ST_INVALID, 20'h5, 8'd0, 1'b0, 12'd0});
		// small zone plus a zone wrapping the top of page space
		add(1, rpa_pkg::CFG_Z0_BASE, 20'h100, 0, '0);
		add(1, rpa_pkg::CFG_Z0_PAGES, 20'd2, 0, '0);
		add(1, rpa_pkg::CFG_Z1_BASE, 20'hFFFFE, 0, '0);
		add(1, rpa_pkg::CFG_Z1_PAGES, 20'd4, 0, '0);
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 1,
			'{rpa_pkg::ST_OK, 20'h101, 8'd1, 1'b0, 12'd5});
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 1,
			'{rpa_pkg::ST_OK, 20'h100, 8'd1, 1'b0, 12'd4});
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 1,
			'{rpa_pkg::ST_OK, 20'h00001, 8'd1, 1'b0, 12'd3});
		add(0, rpa_pkg::OP_READ, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_INCR, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_DECR, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_DECR, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_DECR, 20'h100, 1,
			'{rpa_pkg::ST_NOTUSED, 20'h100, 8'd0, 1'b0, 12'd4});
		add(0, rpa_pkg::OP_INCR, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_READ, 20'h100, 0, '0);
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 0, '0);
		add(0, rpa_pkg::OP_READ, 20'h00001, 1,
			'{rpa_pkg::ST_INVALID, 20'h00001, 8'd0, 1'b0, 12'd3});
		add(0, rpa_pkg::OP_READ, 20'hFFFFF, 0, '0);
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 0, '0);
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 0, '0);
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 1,
			'{rpa_pkg::ST_OK, 20'hFFFFE, 8'd1, 1'b0, 12'd0});
		add(0, rpa_pkg::OP_ALLOC, 20'h0, 1,
			'{rpa_pkg::ST_NOMEM, 20'h0, 8'd0, 1'b0, 12'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) write_reg(plan[i].op, plan[i].page);
			else send(plan[i].op, plan[i].page, plan[i].typed, plan[i].want);
		end

		// random phases over several zone settings and idling patterns
		sender_idle = 0; recv_stall = 0;
		set_zones(20'h100, 20'd8, 20'h200, 20'd8);
		random_items(200, 0);
		set_zones(20'h0, 20'd1, 20'h0, 20'd0);
		random_items(400, 1);
		sender_idle = 57;
		set_zones(20'h40, 20'd16, 20'h48, 20'd16);
		random_items(150, 0);
		sender_idle = 0; recv_stall = 57;
		set_zones(20'hFFFFF, 20'd2047, 20'h0, 20'd1024);
		hold_req = 1;
		random_items(150, 0);
		sender_idle = 36; recv_stall = 36;
		set_zones(20'h0, 20'd0, 20'hFFFF0, 20'd5);
		random_items(120, 0);

		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("refcounted_page_allocator: match");
		else $display("refcounted_page_allocator: mismatch");
		$finish;
	end
endmodule

@@ files.f @@
design/rpa_pkg.sv
design/rpa_req_if.sv
design/rpa_res_if.sv
design/rpa_front.sv
design/rpa_back.sv
design/refcounted_page_allocator.sv
bench/refcounted_page_allocator_test.sv
